FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the frame writer RTL.
// Depends on nothing; assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define LFW_ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define LFW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFW_ASSERT_SYNC(lbl, clk, rstn, prop, msg)
`define LFW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/lfw_pkg.sv
// Package for the LOAS/LATM frame writer: widths, header constants,
// register indexes, the command type passed from front to back. No dependencies.
package lfw_pkg;

    // Payload length limit and derived widths.
    localparam int MAX_PAYLOAD_BYTES = 959;
    localparam int LEN_W             = 10;
    localparam int LEN_TOP           = (1 << LEN_W) - 1;
    localparam int MAX_LEN           = (MAX_PAYLOAD_BYTES < LEN_TOP) ? MAX_PAYLOAD_BYTES
                                                                     : LEN_TOP;
    localparam int ESC_STEP          = 255;
    localparam int ESC_MAX           = MAX_LEN / ESC_STEP;
    localparam int ESC_W             = (ESC_MAX < 2) ? 1 : $clog2(ESC_MAX + 1);
    localparam int MUX_W             = 13;
    localparam int CNT_W             = 3;

    // Command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SBR_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PS_ENABLE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_RATE_INDEX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_CONFIG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_RATE_INDEX  = 3'd4;
    localparam logic [3:0] RST_CORE_RATE_INDEX = 4'd5;
    localparam logic [3:0] RST_CHANNEL_CONFIG  = 4'd1;
    localparam logic [3:0] RST_EXT_RATE_INDEX  = 4'd5;

    // Header constants.
    localparam logic [7:0] SYNC_B0      = 8'h56;
    localparam logic [2:0] SYNC_B1_HI   = 3'b111;
    localparam logic [7:0] MUX_B3       = 8'h20;
    localparam logic [7:0] MUX_B4       = 8'h00;
    localparam logic [4:0] AOT_LC       = 5'b00010;
    localparam logic [4:0] AOT_SBR      = 5'b00101;
    localparam logic [4:0] AOT_PS       = 5'b11101;
    localparam logic [2:0] GA_CFG_BITS  = 3'b100;
    localparam logic [2:0] FRAME_LEN_TYPE = 3'b000;
    localparam logic [7:0] FULLNESS     = 8'hFF;
    localparam logic [1:0] MUX_FLAGS    = 2'b00;
    localparam logic [7:0] ESC_BYTE     = 8'hFF;
    // Mux length is payload + escape bytes + this base (header bytes after length).
    localparam logic [MUX_W-1:0] MUX_BASE_LC  = 13'd7;
    localparam logic [MUX_W-1:0] MUX_BASE_SBR = 13'd8;

    // One command per accepted item.
    typedef struct packed {
        logic               start;    // first item of a frame: emit header
        logic               last;     // frame ends with this item
        logic               has_pay;  // payload byte is part of the frame
        logic               sbr;
        logic               ps;
        logic [3:0]         core;
        logic [3:0]         chan;
        logic [3:0]         ext;
        logic [ESC_W-1:0]   esc;
        logic [7:0]         rem;
        logic [MUX_W-1:0]   mux_len;
        logic [7:0]         payload;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Number of whole 255 steps in a length.
    function automatic logic [ESC_W-1:0] esc_of(input logic [LEN_W-1:0] len);
        logic [ESC_W-1:0] e;
        e = '0;
        for (int k = 1; k <= ESC_MAX; k++) begin
            if ({1'b0, len} >= (LEN_W + 1)'(k * ESC_STEP)) begin
                e = ESC_W'(k);
            end
        end
        return e;
    endfunction

endpackage

FILE: hw/rtl/lfw_if.sv
// Stream interfaces of the frame writer: input item and output byte channels.
// Depends on lfw_pkg for field widths.
interface lfw_in_if import lfw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] frame_length;
    modport source (output valid, output payload_byte, output frame_length, input ready);
    modport sink   (input valid, input payload_byte, input frame_length, output ready);
endinterface

interface lfw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
    modport source (output valid, output out_byte, output end_of_run, output end_of_frame,
                    input ready);
    modport sink   (input valid, input out_byte, input end_of_run, input end_of_frame,
                    output ready);
endinterface

FILE: hw/rtl/lfw_front.sv
// Front end: configuration registers, frame tracking and item classification.
// Depends on lfw_pkg and lfw_if; feeds commands into lfw_cmd_queue.
module lfw_front import lfw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lfw_in_if.sink                in_ch,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic             r_sbr, r_ps;
    logic [3:0]       r_core, r_chan, r_ext;
    logic [LEN_W-1:0] r_left, n_left;
    logic [LEN_W-1:0] len_sat, rem_w;
    logic [ESC_W-1:0] esc;
    logic             start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbr  <= 1'b0;
            r_ps   <= 1'b0;
            r_core <= RST_CORE_RATE_INDEX;
            r_chan <= RST_CHANNEL_CONFIG;
            r_ext  <= RST_EXT_RATE_INDEX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SBR_ENABLE:      r_sbr  <= i_cfg_wdata[0];
                CFG_PS_ENABLE:       r_ps   <= i_cfg_wdata[0];
                CFG_CORE_RATE_INDEX: r_core <= i_cfg_wdata;
                CFG_CHANNEL_CONFIG:  r_chan <= i_cfg_wdata;
                CFG_EXT_RATE_INDEX:  r_ext  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !i_q_full;
    assign o_push      = in_ch.valid && in_ch.ready;
    assign start       = (r_left == '0);

    always_comb begin
        len_sat = ({1'b0, in_ch.frame_length} > (LEN_W + 1)'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                                         : in_ch.frame_length;
        esc     = esc_of(len_sat);
        rem_w   = len_sat - LEN_W'(esc) * LEN_W'(ESC_STEP);

        o_cmd.start   = start;
        o_cmd.last    = start ? (len_sat <= LEN_W'(1)) : (r_left == LEN_W'(1));
        o_cmd.has_pay = start ? (len_sat != '0) : 1'b1;
        o_cmd.sbr     = r_sbr;
        o_cmd.ps      = r_ps;
        o_cmd.core    = r_core;
        o_cmd.chan    = r_chan;
        o_cmd.ext     = r_ext;
        o_cmd.esc     = esc;
        o_cmd.rem     = rem_w[7:0];
        o_cmd.mux_len = MUX_W'(len_sat) + MUX_W'(esc) + (r_sbr ? MUX_BASE_SBR : MUX_BASE_LC);
        o_cmd.payload = in_ch.payload_byte;

        if (start) begin
            n_left = (len_sat == '0) ? '0 : len_sat - LEN_W'(1);
        end else begin
            n_left = r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_push) begin
            r_left <= n_left;
        end
    end

endmodule

FILE: hw/rtl/lfw_cmd_queue.sv
// Small command queue between the front end and the byte sequencer.
// Depends on lfw_pkg for the command type and depth.
module lfw_cmd_queue import lfw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full       = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/lfw_back.sv
// Back end: expands each queued command into frame bytes, one per cycle
// unless stalled, via a registered output stage. Depends on lfw_pkg, lfw_if.
module lfw_back import lfw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_head,
    output logic    o_pop,
    lfw_out_if.source out_ch
);

    localparam logic [2:0] PH_BEGIN = 3'd0;
    localparam logic [2:0] PH_FIX   = 3'd1;
    localparam logic [2:0] PH_CFG   = 3'd2;
    localparam logic [2:0] PH_ESC   = 3'd3;
    localparam logic [2:0] PH_REM   = 3'd4;
    localparam logic [2:0] PH_PAY   = 3'd5;
    localparam logic [2:0] PH_FIN   = 3'd6;
    localparam logic [CNT_W-1:0] FIX_LAST = 3'd4;

    logic [2:0]       r_ph, n_ph, ph;
    logic [CNT_W-1:0] r_cnt, n_cnt, cfg_last;
    logic [7:0]       r_hold, n_hold;
    logic             r_ksel, n_ksel;
    logic             r_ov, r_eor, r_eof;
    logic [7:0]       r_byte;
    logic             can_emit, step, done, eof;
    logic [7:0]       byte_v, cfg_byte, merge_v, merge_in;
    logic [28:0]      asc_lc;
    logic [37:0]      asc_sbr;
    logic [39:0]      hdr;
    t_cmd             c;

    assign c        = i_head.cmd;
    assign can_emit = !r_ov || out_ch.ready;
    assign step     = i_head.valid && can_emit;
    assign o_pop    = step && done;

    // Left-justified header bits from the audio config up to the flag bits.
    assign asc_lc  = {AOT_LC, c.core, c.chan, GA_CFG_BITS, FRAME_LEN_TYPE, FULLNESS, MUX_FLAGS};
    assign asc_sbr = {(c.ps ? AOT_PS : AOT_SBR), c.core, c.chan, c.ext, AOT_LC, GA_CFG_BITS,
                      FRAME_LEN_TYPE, FULLNESS, MUX_FLAGS};
    assign hdr      = c.sbr ? {asc_sbr, 2'b00} : {asc_lc, 11'd0};
    assign cfg_last = c.sbr ? CNT_W'(3) : CNT_W'(2);

    always_comb begin
        case (r_cnt)
            3'd0:    cfg_byte = hdr[39:32];
            3'd1:    cfg_byte = hdr[31:24];
            3'd2:    cfg_byte = hdr[23:16];
            default: cfg_byte = hdr[15:8];
        endcase
    end

    // Held bits sit in the low part of r_hold: six with SBR, five without.
    always_comb begin
        if (r_ph == PH_REM) begin
            merge_in = c.rem;
        end else if (r_ph == PH_ESC) begin
            merge_in = ESC_BYTE;
        end else begin
            merge_in = c.payload;
        end
        merge_v = r_ksel ? {r_hold[5:0], merge_in[7:6]} : {r_hold[4:0], merge_in[7:5]};
    end

    always_comb begin
        ph     = (r_ph == PH_BEGIN) ? (c.start ? PH_FIX : PH_PAY) : r_ph;
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_hold = r_hold;
        n_ksel = r_ksel;
        byte_v = '0;
        eof    = 1'b0;
        done   = 1'b0;
        case (ph)
            PH_FIX: begin
                case (r_cnt)
                    3'd0: begin
                        byte_v = SYNC_B0;
                        n_ksel = c.sbr;
                    end
                    3'd1:    byte_v = {SYNC_B1_HI, c.mux_len[12:8]};
                    3'd2:    byte_v = c.mux_len[7:0];
                    3'd3:    byte_v = MUX_B3;
                    default: byte_v = MUX_B4;
                endcase
                if (r_cnt == FIX_LAST) begin
                    n_ph  = PH_CFG;
                    n_cnt = '0;
                end else begin
                    n_ph  = PH_FIX;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            PH_CFG: begin
                byte_v = cfg_byte;
                if (r_cnt == cfg_last) begin
                    // Unsent tail is the end of fullness plus the two flags.
                    n_hold = {FULLNESS[5:0], MUX_FLAGS};
                    n_cnt  = '0;
                    n_ph   = (c.esc != '0) ? PH_ESC : PH_REM;
                end else begin
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end
            PH_ESC: begin
                byte_v = merge_v;
                n_hold = ESC_BYTE;
                if ((r_cnt + CNT_W'(1)) == CNT_W'(c.esc)) begin
                    n_ph  = PH_REM;
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            PH_REM: begin
                byte_v = merge_v;
                n_hold = c.rem;
                n_ph   = c.has_pay ? PH_PAY : PH_FIN;
            end
            PH_PAY: begin
                byte_v = merge_v;
                n_hold = c.payload;
                if (c.last) begin
                    n_ph = PH_FIN;
                end else begin
                    n_ph = PH_BEGIN;
                    done = 1'b1;
                end
            end
            PH_FIN: begin
                byte_v = r_ksel ? {r_hold[5:0], 2'b00} : {r_hold[4:0], 3'b000};
                eof    = 1'b1;
                done   = 1'b1;
                n_ph   = PH_BEGIN;
            end
            default: begin
                n_ph = PH_BEGIN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_BEGIN;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (step) begin
                r_ph  <= n_ph;
                r_cnt <= n_cnt;
                r_ov  <= 1'b1;
            end else if (out_ch.ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_hold <= n_hold;
            r_ksel <= n_ksel;
            r_byte <= byte_v;
            r_eor  <= done;
            r_eof  <= eof;
        end
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.out_byte     = r_byte;
    assign out_ch.end_of_run   = r_eor;
    assign out_ch.end_of_frame = r_eof;

endmodule

FILE: hw/rtl/loas_latm_frame_writer_unit.sv
// Top level of the LOAS/LATM sync frame writer.
// Depends on lfw_pkg, lfw_if, lfw_front, lfw_cmd_queue, lfw_back, assert_macros.svh.
//
//  Channel   Direction  Handshake      Payload
//  i_in      sink       valid/ready    payload_byte[7:0], frame_length[9:0]
//  o_out     source     valid/ready    out_byte[7:0], end_of_run, end_of_frame
//  i_cfg_*   sink       write enable   i_cfg_idx[2:0], i_cfg_wdata[3:0]
//
// A payload item yields one output byte, and the frame's last item two (its
// byte plus the padded closing byte). A frame's first item yields one output
// byte per part: five fixed bytes, three or four config bytes, up to three
// escape bytes, the length byte, its payload byte unless the frame is empty
// and, for a frame of zero or one byte, the closing byte.
// Reset is synchronous and active low; it clears control state only.
// A four-entry command queue between the front end and the sequencer keeps
// accepting input items while the output side stalls or is busy, until full.
`include "assert_macros.svh"

module loas_latm_frame_writer_unit import lfw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lfw_in_if.sink                i_in,
    lfw_out_if.source             o_out
);

    // Commands produced by the front end, one per accepted item.
    t_cmd    cmd;
    logic    q_push;
    logic    q_full;
    // Head of the queue as seen by the sequencer, and its release.
    t_q_head q_head;
    logic    q_pop;

    // The front end holds the registers and counts the bytes left in the frame.
    // It snapshots the registers into each command, so the header always uses
    // the values that were current when the frame's first item arrived.
    lfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (cmd)
    );

    lfw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // The sequencer walks the header, escape bytes, length byte and payload,
    // keeping the five or six unaligned bits between bytes in a small holder.
    lfw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .out_ch  (o_out)
    );

    // The closing byte of a frame is always the last byte of its item.
    `LFW_ASSERT_SYNC(a_eof_ends_run, i_clk, i_rst_n, o_out.valid && o_out.end_of_frame |-> o_out.end_of_run, "end of frame without end of run")
    // A new output byte can only come from a queued command.
    `LFW_ASSERT_SYNC(a_out_from_queue, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(q_head.valid), "output byte with empty queue")
    // Releasing a command leaves its final byte in the output register.
    `LFW_ASSERT_SYNC(a_pop_shows_last, i_clk, i_rst_n, q_pop |=> o_out.valid && o_out.end_of_run, "command released without last byte")
    // Input back-pressure only comes from a queue that holds commands.
    `LFW_ASSERT_SYNC(a_stall_has_work, i_clk, i_rst_n, !i_in.ready |-> q_head.valid, "input stalled with empty queue")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the LOAS/LATM sync frame writer (loas_latm_frame_writer_unit).
// Depends on lfw_pkg and the stream interfaces in lfw_if; a small class predicts the frame
// bytes from each accepted item, and plain tasks drive the configuration and item channels.
`timescale 1ns / 100ps

module tb_top;
    import lfw_pkg::*;

    // Run shape. Each phase drains the block, rewrites the configuration (phase 0
    // keeps the reset one) and then streams frames under one idling pattern.
    localparam int NUM_PHASES      = 4;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT  = 4000;

    // One byte of the sync frame as the output channel presents it.
    typedef struct {
        bit [7:0] data;
        bit       eor;
        bit       eof;
    } sync_byte_t;

    // Predicts the sync frame byte stream from the accepted items and holds the bytes
    // still owed by the block, oldest first.
    class frame_sync_model;
        bit          sbr_on;
        bit          ps_on;
        bit [3:0]    core_idx;
        bit [3:0]    chan_cfg;
        bit [3:0]    ext_idx;
        int unsigned pay_left;
        bit [7:0]    acc;
        int unsigned acc_bits;
        sync_byte_t  step_bytes[$];
        sync_byte_t  owed_bytes[$];
        int unsigned faults;

        function new();
            sbr_on   = 1'b0;
            ps_on    = 1'b0;
            core_idx = RST_CORE_RATE_INDEX;
            chan_cfg = RST_CHANNEL_CONFIG;
            ext_idx  = RST_EXT_RATE_INDEX;
            pay_left = 0;
            acc      = '0;
            acc_bits = 0;
            faults   = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SBR_ENABLE:      sbr_on   = val[0];
                CFG_PS_ENABLE:       ps_on    = val[0];
                CFG_CORE_RATE_INDEX: core_idx = val;
                CFG_CHANNEL_CONFIG:  chan_cfg = val;
                CFG_EXT_RATE_INDEX:  ext_idx  = val;
                default: ;
            endcase
        endfunction

        function void emit(bit [7:0] b, bit eof);
            sync_byte_t s;
            s.data = b;
            s.eor  = 1'b0;
            s.eof  = eof;
            step_bytes.push_back(s);
        endfunction

        // Shifts the low n bits of val, MSB first, into the unaligned stream.
        function void shift_in(bit [31:0] val, int n);
            for (int k = n - 1; k >= 0; k--) begin
                acc = {acc[6:0], val[k]};
                acc_bits++;
                if (acc_bits == 8) begin
                    emit(acc, 1'b0);
                    acc      = '0;
                    acc_bits = 0;
                end
            end
        endfunction

        // The closing byte is always emitted; it is all zero when the stream is aligned.
        function void close_frame();
            emit((acc_bits == 0) ? 8'h00 : 8'(acc << (8 - acc_bits)), 1'b1);
            acc      = '0;
            acc_bits = 0;
            pay_left = 0;
        endfunction

        function void add_payload(bit [7:0] b);
            shift_in(b, 8);
            if (pay_left > 0) pay_left--;
            if (pay_left == 0) close_frame();
        endfunction

        function void predict_frame_bytes(bit [7:0] pb, bit [LEN_W-1:0] fl);
            int unsigned len;
            int unsigned esc;
            int unsigned nbits;
            int unsigned mux_len;
            step_bytes.delete();
            if (pay_left != 0) begin
                add_payload(pb);
            end else begin
                // Lengths beyond the limit are clamped before anything is derived from them.
                len = fl;
                if (len > MAX_PAYLOAD_BYTES) len = MAX_PAYLOAD_BYTES;
                esc     = len / 255;
                nbits   = (sbr_on ? 25 : 16) + 13 + 8 * (esc + 1) + 8 * len;
                mux_len = (nbits + 7) / 8 + 2;
                acc      = '0;
                acc_bits = 0;
                emit(SYNC_B0, 1'b0);
                emit({SYNC_B1_HI, 5'(mux_len >> 8)}, 1'b0);
                emit(8'(mux_len), 1'b0);
                emit(MUX_B3, 1'b0);
                emit(MUX_B4, 1'b0);
                if (sbr_on) begin
                    shift_in(ps_on ? AOT_PS : AOT_SBR, 5);
                    shift_in(core_idx, 4);
                    shift_in(chan_cfg, 4);
                    shift_in(ext_idx, 4);
                    shift_in(AOT_LC, 5);
                    shift_in(GA_CFG_BITS, 3);
                end else begin
                    shift_in(AOT_LC, 5);
                    shift_in(core_idx, 4);
                    shift_in(chan_cfg, 4);
                    shift_in(GA_CFG_BITS, 3);
                end
                shift_in(FRAME_LEN_TYPE, 3);
                shift_in(FULLNESS, 8);
                shift_in(MUX_FLAGS, 2);
                for (int k = 0; k < esc; k++) shift_in(ESC_BYTE, 8);
                shift_in(len % 255, 8);
                // An empty frame closes on its only item and its byte is dropped.
                if (len == 0) begin
                    close_frame();
                end else begin
                    pay_left = len;
                    add_payload(pb);
                end
            end
            step_bytes[step_bytes.size() - 1].eor = 1'b1;
            foreach (step_bytes[k]) owed_bytes.push_back(step_bytes[k]);
        endfunction

        function void check_byte(bit [7:0] d, bit eor, bit eof);
            sync_byte_t want;
            if (owed_bytes.size() == 0) begin
                $display("%0t: unexpected output byte: expected none, actual %h eor %0d eof %0d",
                         $time, d, eor, eof);
                faults++;
                return;
            end
            want = owed_bytes.pop_front();
            if (want.data != d) begin
                $display("%0t: out_byte expected %h actual %h", $time, want.data, d);
                faults++;
            end
            if (want.eor != eor) begin
                $display("%0t: end_of_run expected %0d actual %0d", $time, want.eor, eor);
                faults++;
            end
            if (want.eof != eof) begin
                $display("%0t: end_of_frame expected %0d actual %0d", $time, want.eof, eof);
                faults++;
            end
        endfunction

        function int pending_count();
            return owed_bytes.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    lfw_in_if  in_ch ();
    lfw_out_if out_ch ();

    loas_latm_frame_writer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    frame_sync_model model;

    // Idling percentages are set by the stimulus process only; the receiver reads them.
    int unsigned send_idle_pct;
    int unsigned rx_stall_pct;
    int          phase_no;
    int unsigned items_sent;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned quiet_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: ready changes on the falling edge. Once, at the start of the hold phase,
    // it holds off for a long stretch so that the command queue fills and the input stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (phase_no == HOLD_PHASE && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Every accepted output byte is checked against the oldest predicted byte.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            model.check_byte(out_ch.out_byte, out_ch.end_of_run, out_ch.end_of_frame);
        end
    end

    // Watchdog: the run is stuck if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d bytes still owed", $time,
                     model.pending_count());
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, idling first at the current rate, and notes it once accepted.
    // Valid stays high afterwards so that back-to-back items go out without a gap in valid.
    task automatic send_item(input bit [7:0] pb, input bit [LEN_W-1:0] fl);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= pb;
        in_ch.frame_length <= fl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model.predict_frame_bytes(pb, fl);
        items_sent++;
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Sends a whole frame. The length field only matters on the first item, so the
    // later items carry random lengths. A negative fill means random payload bytes.
    task automatic send_frame(input int unsigned len_field, input int fill);
        int unsigned len;
        len = (len_field > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : len_field;
        send_item((fill < 0) ? 8'($urandom) : 8'(fill), LEN_W'(len_field));
        for (int k = 1; k < len; k++) begin
            send_item((fill < 0) ? 8'($urandom) : 8'(fill), LEN_W'($urandom));
        end
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        model.write_reg(idx, val);
    endtask

    // Waits until every predicted byte has come out, then lets the block settle.
    task automatic wait_for_drain();
        while (model.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly short frames, with empty frames now and then.
    function automatic int unsigned pick_frame_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return 0;
        if (r < 90) return $urandom_range(16, 1);
        return $urandom_range(60, 17);
    endfunction

    // Phase 1 writes every register to its minimum, phase 2 to its maximum with
    // parametric stereo, phase 3 plain SBR with random indexes; phase 3 also writes
    // the unused indexes, which must leave the configuration alone.
    task automatic configure_phase(input int ph);
        bit [CFG_DATA_W-1:0] v_sbr;
        bit [CFG_DATA_W-1:0] v_ps;
        bit [CFG_DATA_W-1:0] v_core;
        bit [CFG_DATA_W-1:0] v_chan;
        bit [CFG_DATA_W-1:0] v_ext;
        if (ph == 0) return;
        v_sbr  = CFG_DATA_W'($urandom_range(1));
        v_ps   = CFG_DATA_W'($urandom_range(1));
        v_core = CFG_DATA_W'($urandom);
        v_chan = CFG_DATA_W'($urandom);
        v_ext  = CFG_DATA_W'($urandom);
        case (ph)
            1: begin
                v_sbr = '0; v_ps = '0; v_core = '0; v_chan = '0; v_ext = '0;
            end
            2: begin
                v_sbr = CFG_DATA_W'(1); v_ps = CFG_DATA_W'(1);
                v_core = '1; v_chan = '1; v_ext = '1;
            end
            3: begin
                v_sbr = CFG_DATA_W'(1); v_ps = '0;
            end
            default: ;
        endcase
        write_reg(CFG_SBR_ENABLE, v_sbr);
        write_reg(CFG_PS_ENABLE, v_ps);
        write_reg(CFG_CORE_RATE_INDEX, v_core);
        write_reg(CFG_CHANNEL_CONFIG, v_chan);
        write_reg(CFG_EXT_RATE_INDEX, v_ext);
        if (ph >= 3) begin
            for (int k = 1; k <= 3; k++) begin
                write_reg(CFG_IDX_W'(CFG_EXT_RATE_INDEX + k), CFG_DATA_W'($urandom));
            end
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Phase 0 runs the directed frames on the reset configuration: empty frames with
    // both byte extremes, single-byte frames, and a few short ones. The other phases
    // open with an empty and a one-byte frame and then go random. The last phase
    // carries one long frame of exactly one escape step.
    task automatic run_phase(input int ph);
        int unsigned first_item;
        int          big_len;
        first_item = items_sent;
        if (ph == 0) begin
            send_frame(0, 8'hFF);
            send_frame(0, 8'h00);
            send_frame(1, 8'h00);
            send_frame(1, 8'hFF);
            send_frame(2, -1);
            send_frame(3, 8'hFF);
            send_frame(7, 8'h00);
            send_frame(5, -1);
        end else begin
            send_frame(0, -1);
            send_frame(1, -1);
            case (ph)
                3:       big_len = 255;
                default: big_len = -1;
            endcase
            while (items_sent - first_item < ITEMS_PER_PHASE) begin
                if (big_len >= 0 && items_sent - first_item >= ITEMS_PER_PHASE / 2) begin
                    send_frame(big_len, -1);
                    big_len = -1;
                end else begin
                    send_frame(pick_frame_length(), -1);
                end
            end
        end
        stop_items();
    endtask

    initial begin
        model         = new();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        phase_no      = -1;
        items_sent    = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        quiet_cycles  = 0;

        // Every input is known from time zero.
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.payload_byte = '0;
        in_ch.frame_length = '0;
        out_ch.ready       = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idling cycles through: none, sender idle, receiver stalling, both lightly.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_drain();
            phase_no = ph;
            case (ph % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 78; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 78; end
                default: begin send_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            configure_phase(ph);
            run_phase(ph);
        end

        wait_for_drain();
        if (model.pending_count() != 0) begin
            $display("%0t: %0d predicted bytes never came out", $time, model.pending_count());
            model.faults++;
        end
        if (model.faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: loas_latm_frame_writer_unit.f
+incdir+hw/rtl
hw/rtl/lfw_pkg.sv
hw/rtl/lfw_if.sv
hw/rtl/lfw_front.sv
hw/rtl/lfw_cmd_queue.sv
hw/rtl/lfw_back.sv
hw/rtl/loas_latm_frame_writer_unit.sv
dv/tb_top.sv
